@@ hw/rtl/svp_pkg.sv @@
// ----------------------------------------------------------------------------
// svp_pkg
// Shared types and constants for the serial angle command to servo pulse
// block: byte codes, status codes, result beat layout and the pulse table.
// ----------------------------------------------------------------------------
package svp_pkg;

   // field widths
   localparam int ByteWidth  = 8;
   localparam int AngleWidth = 10;
   localparam int PulseWidth = 13;
   localparam int WideWidth  = 14;

   // byte codes
   localparam logic [ByteWidth-1:0] BYTE_CR  = 8'd13;
   localparam logic [ByteWidth-1:0] BYTE_LF  = 8'd10;
   localparam logic [ByteWidth-1:0] DIGIT_LO = 8'd48;
   localparam logic [ByteWidth-1:0] DIGIT_HI = 8'd57;

   // value limits
   localparam logic [WideWidth-1:0]  VALUE_MAX = 14'd999;
   localparam logic [AngleWidth-1:0] ANGLE_MAX = 10'd180;
   localparam logic [PulseWidth-1:0] PULSE_RESET = 13'd2900;

   // integer forms used to build the pulse table
   localparam int AngleLimit = 180;
   localparam int PulseBase  = 1000;
   localparam int PulseSpan  = 3800;
   localparam int TableDepth = 256;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_BAD   = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      status_type            status;
      logic [AngleWidth-1:0] angle;
      logic [PulseWidth-1:0] pulse;
   } result_type;

   typedef logic [0:TableDepth-1][PulseWidth-1:0] pulse_table_type;

   // compare value for each angle, unused entries read as zero
   function automatic pulse_table_type build_pulse_table();
      pulse_table_type t;
      for (int i = 0; i < TableDepth; i++) begin
         if (i <= AngleLimit) begin
            t[i] = PulseWidth'(PulseBase + (i * PulseSpan) / AngleLimit);
         end else begin
            t[i] = '0;
         end
      end
      return t;
   endfunction

   localparam pulse_table_type PULSE_TABLE = build_pulse_table();

endpackage

@@ hw/rtl/svp_in_stage.sv @@
// ----------------------------------------------------------------------------
// svp_in_stage
// Input register for received bytes; holds a beat until the parser takes it.
// ----------------------------------------------------------------------------
module svp_in_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [svp_pkg::ByteWidth-1:0] req_rx_byte,
   input  logic                          take,
   output logic                          byte_valid,
   output logic [svp_pkg::ByteWidth-1:0] byte_data
);
   import svp_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   logic [ByteWidth-1:0] byte_ff;
   logic                 load;

   // stall only while a held beat cannot move on
   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;

   // valid tracking
   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // byte payload
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

@@ hw/rtl/svp_line_parser.sv @@
// ----------------------------------------------------------------------------
// svp_line_parser
// Line state (count, running value, bad flag) and the servo compare value;
// builds the result beat at the end of a non-empty line.
// ----------------------------------------------------------------------------
module svp_line_parser #(
   parameter int LINE_LIMIT = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [svp_pkg::ByteWidth-1:0] byte_data,
   input  logic                          go,
   output logic                          has_result,
   output svp_pkg::result_type           result
);
   import svp_pkg::*;

   localparam int CountWidth = $clog2(LINE_LIMIT + 1);
   localparam logic [CountWidth-1:0] CountLimit = CountWidth'(LINE_LIMIT);

   logic [CountWidth-1:0] count_ff, count_in;
   logic [AngleWidth-1:0] value_ff, value_in;
   logic                  bad_ff, bad_in;
   logic [PulseWidth-1:0] pulse_ff, pulse_in;

   logic                  is_eol;
   logic                  is_digit;
   logic [3:0]            digit;
   logic [WideWidth-1:0]  value_wide;
   logic [WideWidth-1:0]  next_value;
   logic                  in_range;

   // byte decode
   assign is_eol   = (byte_data == BYTE_CR) || (byte_data == BYTE_LF);
   assign is_digit = (byte_data >= DIGIT_LO) && (byte_data <= DIGIT_HI);
   assign digit    = 4'(byte_data - DIGIT_LO);

   // value times ten plus digit
   assign value_wide = {{(WideWidth-AngleWidth){1'b0}}, value_ff};
   assign next_value = (value_wide << 3) + (value_wide << 1)
                       + {{(WideWidth-4){1'b0}}, digit};

   assign has_result = is_eol && (count_ff != '0);
   assign in_range   = value_ff <= ANGLE_MAX;

   // result beat and next line state
   always_comb begin
      count_in      = count_ff;
      value_in      = value_ff;
      bad_in        = bad_ff;
      pulse_in      = pulse_ff;
      result.status = STATUS_OK;
      result.angle  = value_ff;
      if (is_eol) begin
         if (count_ff != '0) begin
            if (bad_ff) begin
               result.status = STATUS_BAD;
               result.angle  = '0;
            end else if (!in_range) begin
               result.status = STATUS_RANGE;
            end else begin
               pulse_in = PULSE_TABLE[value_ff[7:0]];
            end
            count_in = '0;
            value_in = '0;
            bad_in   = 1'b0;
         end
      end else if (count_ff < CountLimit) begin
         count_in = count_ff + 1'b1;
         if (!bad_ff) begin
            if (!is_digit || (next_value > VALUE_MAX)) begin
               bad_in = 1'b1;
            end else begin
               value_in = AngleWidth'(next_value);
            end
         end
      end
      result.pulse = pulse_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         value_ff <= '0;
         bad_ff   <= 1'b0;
         pulse_ff <= PULSE_RESET;
      end else if (go) begin
         count_ff <= count_in;
         value_ff <= value_in;
         bad_ff   <= bad_in;
         pulse_ff <= pulse_in;
      end
   end

endmodule

@@ hw/rtl/svp_out_stage.sv @@
// ----------------------------------------------------------------------------
// svp_out_stage
// Result register; holds a beat while the receiver stalls.
// ----------------------------------------------------------------------------
module svp_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  svp_pkg::result_type result,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output svp_pkg::result_type held
);
   import svp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // room for a new beat when empty or being taken
   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign held      = data_ff;

endmodule

@@ hw/rtl/serial_angle_command_to_servo_pulse.sv @@
// ----------------------------------------------------------------------------
// serial_angle_command_to_servo_pulse
// Parses decimal angle commands from received bytes and keeps the servo
// compare value.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one received byte per beat. Digits build the angle, CR or
//   LF ends the line; bytes past LINE_LIMIT on a line are ignored.
//   rsp_ channel: one beat per non-empty line with status (accepted,
//   malformed, out of range), parsed angle and the compare value in
//   half-microsecond ticks after the line. Other bytes give no beat.
//   Path: an end-of-line byte is taken into the input register, then parse
//   and pulse table lookup load the result register. Throughput: one byte
//   per cycle while no result waits for room in the result register, set by the
//   single multiply-by-ten-and-add of the line state.
//   Reset: line state cleared, compare value set to 2900 (ninety degrees),
//   no result pending.
//   Stall: a stalled result holds in its register; bytes that give no
//   result keep flowing, and only an end-of-line byte that closes a
//   non-empty line waits for room.
// ----------------------------------------------------------------------------
module serial_angle_command_to_servo_pulse #(
   parameter int LINE_LIMIT = 7
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [svp_pkg::ByteWidth-1:0]  req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [svp_pkg::AngleWidth-1:0] rsp_angle_value,
   output logic [svp_pkg::PulseWidth-1:0] rsp_pulse_ticks
);
   import svp_pkg::*;

   logic                 byte_valid;
   logic [ByteWidth-1:0] byte_data;
   logic                 has_result;
   logic                 out_free;
   logic                 go;
   result_type           result;
   result_type           held;

   // a byte moves on unless it needs a full result register
   assign go = byte_valid && (!has_result || out_free);

   svp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .take        (go),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   svp_line_parser #(
      .LINE_LIMIT (LINE_LIMIT)
   ) u_line_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_data  (byte_data),
      .go         (go),
      .has_result (has_result),
      .result     (result)
   );

   svp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (go && has_result),
      .result    (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .held      (held)
   );

   assign rsp_status      = held.status;
   assign rsp_angle_value = held.angle;
   assign rsp_pulse_ticks = held.pulse;

endmodule

@@ hw/rtl/svp_checker.sv @@
// ----------------------------------------------------------------------------
// svp_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module svp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [1:0]                     rsp_status,
   input logic [svp_pkg::AngleWidth-1:0] rsp_angle_value,
   input logic [svp_pkg::PulseWidth-1:0] rsp_pulse_ticks
);
   import svp_pkg::*;

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown after reset");

   // stalled beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(rsp_status) && $stable(rsp_angle_value)
       && $stable(rsp_pulse_ticks)))
      else $error("stalled result changed");

   // malformed line reports angle zero
   a_bad_angle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_BAD) |-> (rsp_angle_value == '0))
      else $error("malformed line with nonzero angle");

   // out of range means above the angle limit
   a_range_angle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_RANGE) |-> (rsp_angle_value > ANGLE_MAX))
      else $error("out of range status with angle in range");

   // accepted angle gives a compare value inside the servo span
   a_ok_pulse: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_OK) |->
      (rsp_angle_value <= ANGLE_MAX && rsp_pulse_ticks >= 13'd1000
       && rsp_pulse_ticks <= 13'd4800))
      else $error("accepted angle with bad compare value");

endmodule

bind serial_angle_command_to_servo_pulse svp_checker u_svp_checker (.*);
